>>> rtl/afq_pkg.sv
// ----------------------------------------------------------------------------
// afq_pkg
// Shared types, codes and defaults for the alarm FIFO queue.
// ----------------------------------------------------------------------------
package afq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  // fixed field widths of the stream ports
  localparam int KIND_W     = 1;
  localparam int MSG_KIND_W = 2;
  localparam int PAYLOAD_W  = 32;
  localparam int STATUS_W   = 3;
  localparam int TOTAL_W    = 5;

  localparam int IN_TDATA_W  = 40;   // msg_kind + payload, rounded to bytes
  localparam int OUT_TDATA_W = 48;   // status + msg_out + total + alarm, rounded

  localparam logic [KIND_W-1:0]     OP_SEND   = 1'b0;
  localparam logic [KIND_W-1:0]     OP_RECV   = 1'b1;
  localparam logic [MSG_KIND_W-1:0] MK_NORMAL = 2'd0;
  localparam logic [MSG_KIND_W-1:0] MK_ALARM  = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_NO_ROOM  = 3'd1,
    STAT_NULL_MSG = 3'd2,
    STAT_NOT_IMPL = 3'd3,
    STAT_NO_MSG   = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  typedef struct packed {
    status_t                status;
    logic                   got_alarm;
    logic [PAYLOAD_W-1:0]   msg_out;
    logic [TOTAL_W-1:0]     total_count;
    logic                   alarm_count;
  } res_t;

endpackage

>>> rtl/fifo_with_priority_alarm_slot_unit.sv
// ----------------------------------------------------------------------------
// fifo_with_priority_alarm_slot_unit
// Message queue: bounded FIFO of normal messages plus one alarm slot.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  in_     | in  | msg_kind[1:0], payload[33:2]                 | kind
//  out_    | out | status[2:0], msg_out[34:3], total[39:35],    | got_alarm
//          |     | alarm_count[40]                             |
//
//  One item per cycle unless the result is stalled; a receive served from the
//  FIFO blocks input for a fetch state, as the store's read data is registered.
//  Result sits in an output register; the next item is taken in the cycle
//  that result is transferred. Synchronous active-low reset clears pointers,
//  counts and the alarm slot; store contents stay undefined until written.
module fifo_with_priority_alarm_slot_unit #(
  parameter int QUEUE_DEPTH   = afq_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_WIDTH = afq_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [afq_pkg::IN_TDATA_W-1:0]   in_tdata,   // msg_kind, payload
  input  logic                             in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [afq_pkg::OUT_TDATA_W-1:0]  out_tdata,  // status, msg_out, total, alarm
  output logic                             out_tuser   // got_alarm
);
  import afq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  res_t                     res;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [PAYLOAD_WIDTH-1:0] mem_wdata, mem_rdata;

  afq_ctrl #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_msg_kind(in_tdata[MSG_KIND_W-1:0]),
    .in_payload (in_tdata[MSG_KIND_W +: PAYLOAD_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  afq_store #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign out_tdata = {7'b0, res.alarm_count, res.total_count, res.msg_out, res.status};
  assign out_tuser = res.got_alarm;

endmodule

>>> rtl/afq_store.sv
// ----------------------------------------------------------------------------
// afq_store
// Message store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module afq_store #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32,
  localparam int AW           = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [PAYLOAD_WIDTH-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [PAYLOAD_WIDTH-1:0] rdata
);

  logic [PAYLOAD_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/afq_ctrl.sv
// ----------------------------------------------------------------------------
// afq_ctrl
// Pointers, counts, alarm slot, sequencer and result register.
// ----------------------------------------------------------------------------
module afq_ctrl #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32,
  localparam int AW           = $clog2(QUEUE_DEPTH),
  localparam int CW           = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [afq_pkg::KIND_W-1:0]         in_kind,
  input  logic [afq_pkg::MSG_KIND_W-1:0]     in_msg_kind,
  input  logic [afq_pkg::PAYLOAD_W-1:0]      in_payload,
  output logic                               out_valid,
  input  logic                               out_ready,
  output afq_pkg::res_t                      out_res,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output logic [PAYLOAD_WIDTH-1:0]           mem_wdata,
  output logic                               mem_re,
  output logic [AW-1:0]                      mem_raddr,
  input  logic [PAYLOAD_WIDTH-1:0]           mem_rdata
);
  import afq_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [PAYLOAD_WIDTH-1:0] alarm_r, alarm_nxt;
  logic                     alarm_vld_r, alarm_vld_nxt;
  logic                     out_valid_r, out_valid_nxt;
  res_t                     res_r, res_nxt;

  logic [PAYLOAD_WIDTH-1:0] pl;
  status_t                  st;
  logic                     got;
  logic [PAYLOAD_WIDTH-1:0] msg;
  logic                     fetch;
  logic [CW:0]              total;

  assign pl       = PAYLOAD_WIDTH'(in_payload);
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      alarm_r     <= '0;
      alarm_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      cnt_r       <= cnt_nxt;
      alarm_r     <= alarm_nxt;
      alarm_vld_r <= alarm_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    cnt_nxt       = cnt_r;
    alarm_nxt     = alarm_r;
    alarm_vld_nxt = alarm_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr_r;
    mem_wdata     = pl;
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr_r;
    st            = STAT_OK;
    got           = 1'b0;
    msg           = '0;
    fetch         = 1'b0;
    total         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_kind == OP_SEND) begin
            if (pl == '0) begin
              st = STAT_NULL_MSG;
            end else begin
              unique case (in_msg_kind)
                MK_ALARM: begin
                  if (alarm_vld_r) begin
                    st = STAT_NO_ROOM;
                  end else begin
                    alarm_nxt     = pl;
                    alarm_vld_nxt = 1'b1;
                  end
                end
                MK_NORMAL: begin
                  if (cnt_r >= FULL_CNT) begin
                    st = STAT_NO_ROOM;
                  end else begin
                    mem_we     = 1'b1;
                    wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
                    cnt_nxt    = cnt_r + 1'b1;
                  end
                end
                default: st = STAT_NOT_IMPL;
              endcase
            end
          end else begin
            if (alarm_vld_r) begin
              got           = 1'b1;
              msg           = alarm_r;
              alarm_nxt     = '0;
              alarm_vld_nxt = 1'b0;
            end else if (cnt_r == '0) begin
              st = STAT_NO_MSG;
            end else begin
              // head comes out of the store in the next cycle, in S_FETCH
              mem_re     = 1'b1;
              fetch      = 1'b1;
              rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
              cnt_nxt    = cnt_r - 1'b1;
            end
          end
          total               = {1'b0, cnt_nxt} + (CW+1)'(alarm_vld_nxt);
          res_nxt.status      = st;
          res_nxt.got_alarm   = got;
          res_nxt.msg_out     = PAYLOAD_W'(msg);
          res_nxt.total_count = TOTAL_W'(total);
          res_nxt.alarm_count = alarm_vld_nxt;
          if (fetch) begin
            state_nxt = S_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_FETCH: begin
        res_nxt.msg_out = PAYLOAD_W'(mem_rdata);
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/afq_checker.sv
// ----------------------------------------------------------------------------
// afq_checker
// Port-level checks on the result stream of the alarm FIFO queue.
// ----------------------------------------------------------------------------
module afq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [afq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import afq_pkg::*;

  logic [STATUS_W-1:0]  stat;
  logic [PAYLOAD_W-1:0] msg;
  logic [TOTAL_W-1:0]   tot;
  logic                 acnt;

  assign stat = out_tdata[STATUS_W-1:0];
  assign msg  = out_tdata[STATUS_W +: PAYLOAD_W];
  assign tot  = out_tdata[STATUS_W+PAYLOAD_W +: TOTAL_W];
  assign acnt = out_tdata[STATUS_W+PAYLOAD_W+TOTAL_W];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && stat == STAT_NO_MSG |-> tot == '0 && !acnt && msg == '0 && !out_tuser)
    else $error("no_message with a nonempty queue");

  a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> stat == STAT_OK && !acnt)
    else $error("alarm returned but slot still occupied");

  a_nomsg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && stat != STAT_OK |-> msg == '0 && !out_tuser)
    else $error("message returned on a failed transfer");

endmodule

bind fifo_with_priority_alarm_slot_unit afq_checker u_afq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alarm message queue. Send and receive commands
// are streamed in with random idling on both sides. A tracker follows the
// FIFO and the alarm slot and predicts status, returned handle and counts for
// every command. Each result transfer is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
  import afq_pkg::*;

  localparam int                    DEPTH    = DEF_QUEUE_DEPTH;
  localparam logic [MSG_KIND_W-1:0] MK_RSVD2 = 2'd2;
  localparam logic [MSG_KIND_W-1:0] MK_RSVD3 = 2'd3;
  localparam int                    HOLD_LEN = 300;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // msg_kind, payload
  logic                   in_tuser   = 1'b0; // kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // status, msg_out, total, alarm
  logic                   out_tuser;         // got_alarm

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int stall_ticket  = 0;

  // Follows the queue contents and holds the results still to come.
  class alarm_queue_tracker;
    logic [PAYLOAD_W-1:0] fifo_mem [DEPTH];
    int unsigned          head;
    int unsigned          tail;
    int unsigned          n_normal;
    logic [PAYLOAD_W-1:0] alarm_msg;
    bit                   alarm_full;
    res_t                 pending_results [$];
    int unsigned          fails;

    function void note_transfer(logic k, logic [MSG_KIND_W-1:0] mk,
                                logic [PAYLOAD_W-1:0] pl);
      res_t r;
      r.status    = STAT_OK;
      r.got_alarm = 1'b0;
      r.msg_out   = '0;
      if (k == OP_SEND) begin
        if (pl == '0) begin
          r.status = STAT_NULL_MSG;
        end else if (mk == MK_ALARM) begin
          if (alarm_full) begin
            r.status = STAT_NO_ROOM;
          end else begin
            alarm_msg  = pl;
            alarm_full = 1'b1;
          end
        end else if (mk == MK_NORMAL) begin
          if (n_normal >= DEPTH) begin
            r.status = STAT_NO_ROOM;
          end else begin
            fifo_mem[tail] = pl;
            tail           = (tail + 1) % DEPTH;
            n_normal++;
          end
        end else begin
          r.status = STAT_NOT_IMPL;
        end
      end else begin
        // alarm always wins over the FIFO head
        if (alarm_full) begin
          r.got_alarm = 1'b1;
          r.msg_out   = alarm_msg;
          alarm_msg   = '0;
          alarm_full  = 1'b0;
        end else if (n_normal == 0) begin
          r.status = STAT_NO_MSG;
        end else begin
          r.msg_out = fifo_mem[head];
          head      = (head + 1) % DEPTH;
          n_normal--;
        end
      end
      r.total_count = TOTAL_W'(n_normal + alarm_full);
      r.alarm_count = alarm_full;
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, logic [PAYLOAD_W-1:0] want, logic [PAYLOAD_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td, logic tu);
      res_t r;
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding: tdata 0x%0h", td);
        fails++;
        return;
      end
      r = pending_results.pop_front();
      cmp("status",      r.status,      td[2:0]);
      cmp("got_alarm",   r.got_alarm,   tu);
      cmp("msg_out",     r.msg_out,     td[34:3]);
      cmp("total_count", r.total_count, td[39:35]);
      cmp("alarm_count", r.alarm_count, td[40]);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  alarm_queue_tracker tracker = new();

  fifo_with_priority_alarm_slot_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // result side: check transfers, random backpressure, long hold on request
  initial begin
    int hold;
    int stall_seen;
    hold       = 0;
    stall_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
      if (hold > 0) begin
        hold--;
      end else if (stall_ticket != stall_seen) begin
        stall_seen = stall_ticket;
        hold       = HOLD_LEN;
      end
      out_tready <= (hold == 0) && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic put_item(logic k, logic [MSG_KIND_W-1:0] mk, logic [PAYLOAD_W-1:0] pl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {{(IN_TDATA_W - PAYLOAD_W - MSG_KIND_W){1'b0}}, pl, mk};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_transfer(k, mk, pl);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // send bias changes every few dozen commands so the FIFO swings between
  // empty and full
  task automatic run_mix(int count);
    int                   send_bias;
    int                   sel;
    logic                 k;
    logic [MSG_KIND_W-1:0] mk;
    logic [PAYLOAD_W-1:0] pl;
    send_bias = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) send_bias = $urandom_range(90, 15);
      k   = ($urandom_range(99) < send_bias) ? OP_SEND : OP_RECV;
      sel = $urandom_range(99);
      if (sel < 75)      mk = MK_NORMAL;
      else if (sel < 90) mk = MK_ALARM;
      else               mk = $urandom_range(1) ? MK_RSVD2 : MK_RSVD3;
      sel = $urandom_range(99);
      if (sel < 5)      pl = '0;
      else if (sel < 8) pl = '1;
      else              pl = $urandom();
      put_item(k, mk, pl);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty receive, null and unsupported sends, alarm slot taken,
    // full FIFO with alarm on top, alarm served before FIFO head
    put_item(OP_RECV, MK_RSVD3,  '1);
    put_item(OP_SEND, MK_NORMAL, '0);
    put_item(OP_SEND, MK_RSVD3,  '0);
    put_item(OP_SEND, MK_RSVD2,  32'h0000_0001);
    put_item(OP_SEND, MK_RSVD3,  '1);
    put_item(OP_SEND, MK_ALARM,  '1);
    put_item(OP_SEND, MK_ALARM,  32'h5a5a_a5a5);
    for (int i = 0; i < DEPTH; i++) put_item(OP_SEND, MK_NORMAL, 32'h0101_0101 * (i + 1));
    put_item(OP_SEND, MK_NORMAL, 32'h8000_0000);
    put_item(OP_RECV, MK_ALARM,  '0);
    put_item(OP_RECV, MK_NORMAL, '0);
    wait_drained();

    src_idle_pct  = 27;
    sink_idle_pct = 80;
    run_mix(630);
    wait_drained();

    src_idle_pct  = 80;
    sink_idle_pct = 27;
    run_mix(630);
    wait_drained();

    // no idling; the result side holds off for a while so the input stalls
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_ticket++;
    run_mix(620);
    wait_drained();
    repeat (8) @(posedge clk);

    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("PASS fifo_with_priority_alarm_slot_unit");
    end else begin
      $display("FAIL fifo_with_priority_alarm_slot_unit");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL fifo_with_priority_alarm_slot_unit");
    $finish;
  end

endmodule

>>> filelist.f
rtl/afq_pkg.sv
rtl/afq_store.sv
rtl/afq_ctrl.sv
rtl/fifo_with_priority_alarm_slot_unit.sv
rtl/afq_checker.sv
tb/sv/tb.sv
